// ----- sv/jkol_pkg.sv -----
// ----------------------------------------------------------------------------
// jkol_pkg
// Shared constants, codes, types and helpers of the keyed JSON object locator.
// ----------------------------------------------------------------------------
package jkol_pkg;

  // Sizing
  localparam int PATTERN_MAX = 56;
  localparam int TEXT_MAX    = 65536;
  localparam int DEPTH_MAX   = 255;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int PAT_WORDS  = 7;
  localparam int WORD_W     = 64;
  localparam int PAT_BYTES  = PAT_WORDS * WORD_W / BYTE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int OFS_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int POS_W      = $clog2(TEXT_MAX) + 1;
  localparam int DEPTH_W    = $clog2(DEPTH_MAX + 1);
  localparam int PIDX_W     = $clog2(PATTERN_MAX);

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND,
    ST_NOKEY,
    ST_NOBRACE,
    ST_UNBAL,
    ST_OVER
  } status_t;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_BRACE,
    PH_MATCH,
    PH_DONE
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH,
    REG_WORD0,
    REG_WORD1,
    REG_WORD2,
    REG_WORD3,
    REG_WORD4,
    REG_WORD5,
    REG_WORD6
  } cfg_reg_t;

  // Pattern bytes packed flat, byte i at [8i +: 8]
  typedef logic [PAT_WORDS*WORD_W-1:0] pattern_t;

  typedef struct packed {
    logic step;   // shift the current byte into the prefix tracker
    logic clear;  // end of text: forget all partial matches
  } key_ctrl_t;

  typedef struct packed {
    status_t            status;
    logic [OFS_W-1:0]   open_offset;
    logic [OFS_W-1:0]   close_offset;
  } result_t;

  // Out-of-range lengths are clamped to [2, PATTERN_MAX]
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (len < LEN_W'(2)) n = LEN_W'(2);
    else if (len > LEN_W'(PATTERN_MAX)) n = LEN_W'(PATTERN_MAX);
    return n;
  endfunction

  function automatic status_t fail_status(input phase_t ph);
    status_t s;
    case (ph)
      PH_KEY:   s = ST_NOKEY;
      PH_BRACE: s = ST_NOBRACE;
      default:  s = ST_UNBAL;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/jkol_in_if.sv -----
// ----------------------------------------------------------------------------
// jkol_in_if
// Text byte channel: one byte of JSON text per beat.
// ----------------------------------------------------------------------------
interface jkol_in_if import jkol_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// ----- sv/jkol_out_if.sv -----
// ----------------------------------------------------------------------------
// jkol_out_if
// Result channel: one locate result per beat.
// ----------------------------------------------------------------------------
interface jkol_out_if import jkol_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFS_W-1:0]    open_offset;
  logic [OFS_W-1:0]    close_offset;

  modport source (output valid, output status, output open_offset, output close_offset,
                  input ready);
  modport sink   (input valid, input status, input open_offset, input close_offset,
                  output ready);
endinterface

// ----- sv/jkol_cfg_if.sv -----
// ----------------------------------------------------------------------------
// jkol_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface jkol_cfg_if import jkol_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/jkol_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// jkol_cfg_regs
// Pattern length and pattern word registers.
// ----------------------------------------------------------------------------
module jkol_cfg_regs import jkol_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  output logic [LEN_W-1:0]     eff_len,
  output pattern_t             pattern
);

  logic [LEN_W-1:0]  length_r;
  logic [WORD_W-1:0] word_r [PAT_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= LEN_W'(2);
      for (int i = 0; i < PAT_WORDS; i++) word_r[i] <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_LENGTH: length_r <= wr_data[LEN_W-1:0];
        REG_WORD0:  word_r[0] <= wr_data;
        REG_WORD1:  word_r[1] <= wr_data;
        REG_WORD2:  word_r[2] <= wr_data;
        REG_WORD3:  word_r[3] <= wr_data;
        REG_WORD4:  word_r[4] <= wr_data;
        REG_WORD5:  word_r[5] <= wr_data;
        REG_WORD6:  word_r[6] <= wr_data;
        default: ;
      endcase
    end
  end

  assign eff_len = eff_length(length_r);

  always_comb begin
    for (int i = 0; i < PAT_WORDS; i++) pattern[i*WORD_W +: WORD_W] = word_r[i];
  end

endmodule

// ----- sv/jkol_key_matcher.sv -----
// ----------------------------------------------------------------------------
// jkol_key_matcher
// Parallel key search: one prefix-match flag per pattern position.
// ----------------------------------------------------------------------------
module jkol_key_matcher import jkol_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  key_ctrl_t         ctrl,
  input  logic [BYTE_W-1:0] text_byte,
  input  pattern_t          pattern,
  input  logic [LEN_W-1:0]  eff_len,
  output logic              hit
);

  // prefix_r[i]: the last i+1 bytes equal pattern bytes 0..i
  logic [PATTERN_MAX-1:0] prefix_r;
  logic [PATTERN_MAX-1:0] prefix_nxt;
  logic [PATTERN_MAX-1:0] byte_eq;
  logic [LEN_W-1:0]       len_m1;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cmp
    if (i < PAT_BYTES) begin : g_live
      assign byte_eq[i] = (text_byte == pattern[i*BYTE_W +: BYTE_W]);
    end else begin : g_zero
      assign byte_eq[i] = (text_byte == '0);
    end
  end

  assign prefix_nxt = byte_eq & {prefix_r[PATTERN_MAX-2:0], 1'b1};
  assign len_m1     = eff_len - LEN_W'(1);
  assign hit        = prefix_nxt[len_m1[PIDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      prefix_r <= '0;
    end else if (ctrl.step) begin
      prefix_r <= prefix_nxt;
    end
  end

endmodule

// ----- sv/jkol_obj_tracker.sv -----
// ----------------------------------------------------------------------------
// jkol_obj_tracker
// Phase control, offset count and brace depth tracking for one text.
// ----------------------------------------------------------------------------
module jkol_obj_tracker import jkol_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              text_last,
  input  logic              key_hit,
  output key_ctrl_t         key_ctrl,
  output logic              res_valid,
  output result_t           res
);

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [OFS_W-1:0]   start_r, start_nxt;
  logic               in_str_r, in_str_nxt;
  logic               esc_r, esc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_KEY;
      pos_r    <= '0;
      depth_r  <= '0;
      start_r  <= '0;
      in_str_r <= 1'b0;
      esc_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      depth_r  <= depth_nxt;
      start_r  <= start_nxt;
      in_str_r <= in_str_nxt;
      esc_r    <= esc_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    depth_nxt  = depth_r;
    start_nxt  = start_r;
    in_str_nxt = in_str_r;
    esc_nxt    = esc_r;
    key_ctrl   = '0;
    res_valid  = 1'b0;
    res        = '{status: ST_FOUND, open_offset: '0, close_offset: '0};

    if (proc) begin
      if (pos_r < POS_W'(TEXT_MAX)) pos_nxt = pos_r + POS_W'(1);

      if (phase_r != PH_DONE) begin
        if (pos_r >= POS_W'(TEXT_MAX)) begin
          res_valid  = 1'b1;
          res.status = ST_OVER;
          phase_nxt  = PH_DONE;
        end else if (text_byte == CH_NUL) begin
          res_valid  = 1'b1;
          res.status = fail_status(phase_r);
          phase_nxt  = PH_DONE;
        end else begin
          case (phase_r)
            PH_KEY: begin
              key_ctrl.step = 1'b1;
              if (key_hit) phase_nxt = PH_BRACE;
            end
            PH_BRACE: begin
              if (text_byte == CH_LBRACE) begin
                start_nxt  = pos_r[OFS_W-1:0];
                depth_nxt  = DEPTH_W'(1);
                in_str_nxt = 1'b0;
                esc_nxt    = 1'b0;
                phase_nxt  = PH_MATCH;
              end
            end
            PH_MATCH: begin
              if (in_str_r) begin
                if (esc_r) esc_nxt = 1'b0;
                else if (text_byte == CH_BSLASH) esc_nxt = 1'b1;
                else if (text_byte == CH_QUOTE) in_str_nxt = 1'b0;
              end else if (text_byte == CH_QUOTE) begin
                in_str_nxt = 1'b1;
              end else if (text_byte == CH_LBRACE) begin
                if (depth_r >= DEPTH_W'(DEPTH_MAX)) begin
                  res_valid  = 1'b1;
                  res.status = ST_OVER;
                  phase_nxt  = PH_DONE;
                end else begin
                  depth_nxt = depth_r + DEPTH_W'(1);
                end
              end else if (text_byte == CH_RBRACE) begin
                depth_nxt = depth_r - DEPTH_W'(1);
                if (depth_r == DEPTH_W'(1)) begin
                  res_valid        = 1'b1;
                  res.status       = ST_FOUND;
                  res.open_offset  = start_r;
                  res.close_offset = pos_r[OFS_W-1:0];
                  phase_nxt        = PH_DONE;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // end of text: undecided gives the failure of the phase reached
      if (text_last) begin
        if (!res_valid && phase_nxt != PH_DONE) begin
          res_valid  = 1'b1;
          res.status = fail_status(phase_nxt);
        end
        key_ctrl.clear = 1'b1;
        phase_nxt      = PH_KEY;
        pos_nxt        = '0;
        depth_nxt      = '0;
        start_nxt      = '0;
        in_str_nxt     = 1'b0;
        esc_nxt        = 1'b0;
      end
    end
  end

endmodule

// ----- sv/json_keyed_object_locator.sv -----
// ----------------------------------------------------------------------------
// json_keyed_object_locator
// Finds the JSON object that follows a configured quoted key in a byte stream.
// ----------------------------------------------------------------------------
// Takes one text byte per beat, a new beat every cycle, and gives at most one
// result per text. Each byte is held in an input register, is handled
// by the key comparators (all pattern positions in parallel) and the brace
// tracker, and any result lands in the output register. Throughput is one
// byte per clock, limited only by the result register being held by a
// stalled sink. Results: status 0 found with both brace offsets, 1 key
// absent, 2 no brace after the key, 3 text ended unbalanced, 4 text too
// long or nesting too deep; offsets are 0 for any failure. After a result,
// bytes are dropped until text_last. The user must write the pattern
// registers on the cfg channel only between texts; the block does not
// enforce it. cfg_ch.ready is always high.
// ----------------------------------------------------------------------------
module json_keyed_object_locator import jkol_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  jkol_in_if.sink     in_ch,
  jkol_out_if.source  out_ch,
  jkol_cfg_if.sink    cfg_ch
);

  // input register
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_last_r;

  // output register
  logic              out_valid_r;
  result_t           out_res_r;

  logic              advance;
  logic              proc;
  logic [LEN_W-1:0]  eff_len;
  pattern_t          pattern;
  key_ctrl_t         key_ctrl;
  logic              key_hit;
  logic              res_valid;
  result_t           res;

  // pipeline moves unless a result is stuck waiting for the sink
  assign advance      = !out_valid_r || out_ch.ready;
  assign proc         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.text_byte;
      in_last_r <= in_ch.text_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) out_res_r <= res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.open_offset  = out_res_r.open_offset;
  assign out_ch.close_offset = out_res_r.close_offset;

  jkol_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .eff_len  (eff_len),
    .pattern  (pattern)
  );

  jkol_key_matcher u_key_matcher (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (key_ctrl),
    .text_byte (in_byte_r),
    .pattern   (pattern),
    .eff_len   (eff_len),
    .hit       (key_hit)
  );

  jkol_obj_tracker u_obj_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .text_byte (in_byte_r),
    .text_last (in_last_r),
    .key_hit   (key_hit),
    .key_ctrl  (key_ctrl),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

// ----- sv/jkol_checker.sv -----
// ----------------------------------------------------------------------------
// jkol_checker
// Port-level checks on the result channel of the locator.
// ----------------------------------------------------------------------------
module jkol_checker import jkol_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [OFS_W-1:0]    open_offset,
  input logic [OFS_W-1:0]    close_offset
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(open_offset) && $stable(close_offset))
    else $error("result beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_FOUND |-> open_offset == '0 && close_offset == '0)
    else $error("failure result carries offsets");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FOUND |-> close_offset > open_offset)
    else $error("closing brace not after opening brace");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind json_keyed_object_locator jkol_checker u_jkol_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .open_offset  (out_ch.open_offset),
  .close_offset (out_ch.close_offset)
);
